// ===== hdl/rde_pkg.sv =====
package rde_pkg;

	// Value width the conversion works on (4..64)
	localparam int VALUE_BITS = 32;

	// Field widths fixed by the stream format
	localparam int IN_VALUE_W = 32;
	localparam int RADIX_W    = 5;
	localparam int S_TDATA_W  = 40;
	localparam int CHAR_W     = 7;
	localparam int M_TDATA_W  = 8;

	// Long division: quotient bits resolved per cycle
	localparam int DIV_BITS  = 8;
	localparam int VB_PAD    = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int DIV_STEPS = VB_PAD / DIV_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [VB_PAD-1:0] VALUE_MASK = {VB_PAD{1'b1}} >> (VB_PAD - VALUE_BITS);

	// Digit store
	localparam int STORE_DEPTH = 32;
	localparam int IDX_W       = 5;
	localparam int CNT_W       = 6;
	localparam int DIGIT_W     = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

	typedef struct packed {
		logic [VB_PAD-1:0]  value;
		logic [RADIX_W-1:0] radix;
	} rde_item_t;

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_LIMIT) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DECIMAL_LIMIT);
		end
		return c;
	endfunction

endpackage

// ===== hdl/rde_ram.sv =====
module rde_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/rde_front.sv =====
module rde_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rde_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                           item_valid,
	input  logic                           item_ready,
	output rde_pkg::rde_item_t             item
);
	import rde_pkg::*;

	logic               valid_q;
	rde_item_t          item_q;
	logic [63:0]        val_wide;
	logic [RADIX_W-1:0] radix_raw;
	logic [RADIX_W-1:0] radix_clamped;

	assign s_axis_tready = !valid_q || item_ready;
	assign item_valid    = valid_q;
	assign item          = item_q;

	always_comb begin
		val_wide  = 64'(s_axis_tdata[IN_VALUE_W-1:0]);
		radix_raw = s_axis_tdata[IN_VALUE_W +: RADIX_W];
		if (radix_raw < RADIX_MIN) begin
			radix_clamped = RADIX_MIN;
		end else if (radix_raw > RADIX_MAX) begin
			radix_clamped = RADIX_MAX;
		end else begin
			radix_clamped = radix_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_q.value <= val_wide[VB_PAD-1:0] & VALUE_MASK;
			item_q.radix <= radix_clamped;
		end
	end

endmodule

// ===== hdl/rde_queue.sv =====
module rde_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rde_pkg::rde_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rde_pkg::rde_item_t out_item
);
	import rde_pkg::*;

	rde_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ===== hdl/rde_back.sv =====
module rde_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  rde_pkg::rde_item_t            item,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rde_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);
	import rde_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [VB_PAD-1:0]  val_q;
	logic [VB_PAD-1:0]  quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               rd_pend_s1;
	logic               rd_last_s1;

	// Division datapath
	logic [DIV_BITS-1:0]        chunk;
	logic [DIV_BITS-1:0]        qbits;
	logic [DIGIT_W-1:0]         rem_n;
	logic [VB_PAD+DIV_BITS-1:0] qcat;
	logic [VB_PAD+DIV_BITS-1:0] vcat;
	logic [VB_PAD-1:0]          quo_full;
	logic [VB_PAD-1:0]          val_next;
	logic                       digit_done;

	// Store and output queue
	logic               ram_we;
	logic               ram_re;
	logic [DIGIT_W-1:0] ram_rdata;
	logic [CHAR_W-1:0]  oq_char_q [2];
	logic               oq_last_q [2];
	logic               oq_wr_q;
	logic               oq_rd_q;
	logic [1:0]         oq_cnt_q;
	logic [1:0]         oq_after_pop;
	logic               oq_pop;
	logic               issue;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		chunk = val_q[VB_PAD-1 -: DIV_BITS];
		r     = rem_q;
		qbits = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= radix_q) begin
				t        = t - radix_q;
				qbits[i] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_n = r;
	end

	assign qcat       = {quo_q, qbits};
	assign quo_full   = qcat[VB_PAD-1:0];
	assign vcat       = {val_q, {DIV_BITS{1'b0}}};
	assign val_next   = vcat[VB_PAD-1:0];
	assign digit_done = (state_q == ST_DIV) && (step_q == STEP_W'(DIV_STEPS - 1));
	assign ram_we     = digit_done;

	// Prefetch a digit only if the output queue has room once it lands
	assign oq_pop       = m_axis_tvalid && m_axis_tready;
	assign oq_after_pop = oq_cnt_q - 2'(oq_pop);
	assign issue        = (state_q == ST_EMIT)
		&& ((3'(oq_after_pop) + 3'(rd_pend_s1)) <= 3'd1);
	assign ram_re       = issue;

	rde_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (rem_n),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_pend_s1 <= 1'b0;
			cnt_q      <= '0;
		end else begin
			rd_pend_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						cnt_q <= cnt_q + 1'b1;
						if (quo_full == '0 || cnt_q == CNT_W'(STORE_DEPTH - 1)) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (issue && rd_idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_last_s1 <= (rd_idx_q == '0);
		end
		unique case (state_q)
			ST_IDLE: begin
				val_q   <= item.value;
				radix_q <= item.radix;
				quo_q   <= '0;
				rem_q   <= '0;
				step_q  <= '0;
			end
			ST_DIV: begin
				if (digit_done) begin
					val_q    <= quo_full;
					quo_q    <= '0;
					rem_q    <= '0;
					step_q   <= '0;
					rd_idx_q <= cnt_q[IDX_W-1:0];
				end else begin
					val_q  <= val_next;
					quo_q  <= quo_full;
					rem_q  <= rem_n;
					step_q <= step_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (issue) begin
					rd_idx_q <= rd_idx_q - 1'b1;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	// Two-entry output queue fed by the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (rd_pend_s1) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + 2'(rd_pend_s1) - 2'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			oq_char_q[oq_wr_q] <= ascii_of(ram_rdata);
			oq_last_q[oq_wr_q] <= rd_last_s1;
		end
	end

	assign m_axis_tvalid = (oq_cnt_q != 2'd0);
	assign m_axis_tdata  = M_TDATA_W'(oq_char_q[oq_rd_q]);
	assign m_axis_tlast  = oq_last_q[oq_rd_q];

endmodule

// ===== hdl/radix_digit_emitter_unit.sv =====
// Channel   Direction  Payload (lowest bit up)                     Marker
// s_axis    in         tdata: value[31:0], radix[36:32], zero pad   -
// m_axis    out        tdata: digit_char[6:0], zero pad             tlast = last_digit
//
// An item passes through the front register and the queue, then long division
// forms each digit (8 quotient bits per cycle over a 32-bit value) into the
// digit store, then the digits are read back out. The back end takes its next
// item only once the read of the last digit has been issued.
// Reset clears control state only; the digit store needs no clearing pass.
// A stalled m_axis holds the back end once its two-entry output queue fills;
// the queue and front register take up to three more items meanwhile.
module radix_digit_emitter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rde_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], radix[36:32]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rde_pkg::M_TDATA_W-1:0] m_axis_tdata,  // digit_char[6:0]
	output logic                          m_axis_tlast
);
	import rde_pkg::*;

	// Front register to queue
	logic      fr_valid;
	logic      fr_ready;
	rde_item_t fr_item;

	// Queue to back end
	logic      bk_valid;
	logic      bk_ready;
	rde_item_t bk_item;

	// Mask the value, clamp the radix into 2..16
	rde_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.item_valid    (fr_valid),
		.item_ready    (fr_ready),
		.item          (fr_item)
	);

	// Decouple acceptance from the long conversion
	rde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_item  (bk_item)
	);

	// Divide into the digit store, then stream digits most significant first
	rde_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (bk_valid),
		.item_ready    (bk_ready),
		.item          (bk_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/tb_radix_digit_emitter_unit.sv =====
`timescale 1ns / 100ps

module tb_radix_digit_emitter_unit;

	import rde_pkg::*;

	localparam int        RANDOM_ITEMS  = 130;
	localparam int        HOLD_CYCLES   = 500;
	localparam int        HOLD_AT_DIGIT = 150;
	localparam int        TAIL_CYCLES   = 200;
	localparam int        REPORT_LIMIT  = 10;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT0  = 7'h30;       // '0'
	localparam logic [CHAR_W-1:0] CHAR_LETTER0 = 7'h41 - 7'd10; // 'A' minus ten
	localparam logic [4:0] BASE_FLOOR = 5'd2;
	localparam logic [4:0] BASE_CEIL  = 5'd16;

	typedef struct {
		logic [IN_VALUE_W-1:0] value;
		logic [RADIX_W-1:0]    radix;
	} conv_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PATTERN} sink_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	conv_req_t pending_reqs[$];
	digit_t    expected_digits[$];
	int        mismatches = 0;
	int        values_sent = 0;
	int        digits_checked = 0;
	int        longest_backpressure = 0;

	radix_digit_emitter_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expand one value into its digits, most significant first.
	function automatic void queue_digits_of(input conv_req_t req);
		logic [63:0]        rest;
		logic [4:0]         base;
		logic [DIGIT_W-1:0] digits[STORE_DEPTH];
		int                 n;
		digit_t             d;
		rest = 64'(req.value);
		if (VALUE_BITS < 64) begin
			rest &= (64'h1 << VALUE_BITS) - 64'h1;
		end
		base = req.radix;
		if (base < BASE_FLOOR) begin
			base = BASE_FLOOR;
		end
		if (base > BASE_CEIL) begin
			base = BASE_CEIL;
		end
		n = 0;
		do begin
			if (n < STORE_DEPTH) begin
				digits[n] = DIGIT_W'(rest % base);
				n++;
			end
			rest = rest / base;
		end while (rest != 0);
		for (int k = n - 1; k >= 0; k--) begin
			if (digits[k] < 4'd10) begin
				d.digit_char = CHAR_DIGIT0 + CHAR_W'(digits[k]);
			end else begin
				d.digit_char = CHAR_LETTER0 + CHAR_W'(digits[k]);
			end
			d.last_digit = (k == 0);
			expected_digits = {expected_digits, d};
		end
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	function automatic logic [IN_VALUE_W-1:0] pick_value();
		logic [IN_VALUE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(0, 255);
			2: v = $urandom >> $urandom_range(1, 31);
			default: v = {IN_VALUE_W{1'b1}} >> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	function automatic logic [RADIX_W-1:0] pick_radix();
		// mostly legal bases, now and then one that gets clamped
		if ($urandom_range(0, 7) == 0) begin
			return RADIX_W'($urandom_range(0, 31));
		end
		return RADIX_W'($urandom_range(2, 16));
	endfunction

	task automatic add_req(input logic [IN_VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
		conv_req_t req;
		req.value = v;
		req.radix = r;
		pending_reqs = {pending_reqs, req};
	endtask

	// Sender: bursts of items separated by random gaps.
	always @(posedge clk or negedge arst_n) begin : source
		int burst_left;
		int gap_left;
		int stall_run;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left = 0;
			gap_left   = 0;
			stall_run  = 0;
		end else begin
			if (s_axis_tvalid && !s_axis_tready) begin
				stall_run++;
				if (stall_run > longest_backpressure) begin
					longest_backpressure = stall_run;
				end
			end else begin
				stall_run = 0;
				if (s_axis_tvalid) begin
					queue_digits_of(pending_reqs.pop_front());
					values_sent++;
				end
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 8);
					end
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= S_TDATA_W'({pending_reqs[0].radix, pending_reqs[0].value});
					burst_left--;
					if (burst_left == 0) begin
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each digit, stall in randomly chosen modes, hold off once for long.
	always @(posedge clk or negedge arst_n) begin : sink
		sink_mode_t mode;
		int         mode_left;
		int         hold_left;
		bit         hold_done;
		logic [7:0] pattern;
		logic       ready_next;
		digit_t     want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			mode      = SINK_OPEN;
			mode_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
			pattern   = 8'hFF;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digits.size() == 0) begin
					note_mismatch($sformatf("unexpected digit char=%0d last=%0b",
						m_axis_tdata[CHAR_W-1:0], m_axis_tlast));
				end else begin
					want = expected_digits.pop_front();
					if (m_axis_tdata[CHAR_W-1:0] !== want.digit_char) begin
						note_mismatch($sformatf("digit_char expected %0d got %0d",
							want.digit_char, m_axis_tdata[CHAR_W-1:0]));
					end
					if (m_axis_tlast !== want.last_digit) begin
						note_mismatch($sformatf("last_digit expected %0b got %0b",
							want.last_digit, m_axis_tlast));
					end
				end
				digits_checked++;
				if (digits_checked == HOLD_AT_DIGIT && !hold_done) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (mode_left == 0) begin
				mode      = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
				pattern   = 8'($urandom);
			end
			mode_left--;
			pattern = {pattern[6:0], pattern[7]};
			case (mode)
				SINK_OPEN:   ready_next = 1'b1;
				SINK_HALF:   ready_next = 1'($urandom_range(0, 1));
				SINK_SPARSE: ready_next = ($urandom_range(0, 7) == 0);
				default:     ready_next = pattern[0];
			endcase
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end
			m_axis_tready <= ready_next;
		end
	end

	initial begin
		// zero, extremes and clamped bases first
		add_req(32'd0, 5'd10);
		add_req(32'd0, 5'd2);
		add_req(32'hFFFF_FFFF, 5'd2);
		add_req(32'hFFFF_FFFF, 5'd16);
		add_req(32'hFFFF_FFFF, 5'd10);
		add_req(32'hFFFF_FFFF, 5'd3);
		add_req(32'h8000_0000, 5'd2);
		add_req(32'd5, 5'd0);
		add_req(32'hFFFF_FFFF, 5'd1);
		add_req(32'hFFFF_FFFF, 5'd17);
		add_req(32'd255, 5'd31);
		add_req(32'd9, 5'd10);
		add_req(32'd10, 5'd10);
		add_req(32'd999_999_999, 5'd10);
		add_req(32'd1_000_000_000, 5'd10);
		add_req(32'h0ABC_DEF0, 5'd16);
		add_req(32'h1234_5678, 5'd16);
		add_req(32'd14, 5'd15);
		add_req(32'd1, 5'd7);
		add_req(32'h5555_5555, 5'd4);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			add_req(pick_value(), pick_radix());
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_digits.size() > 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_digits.size() != 0) begin
			note_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));
		end

		$display("Converted %0d values in bases 0..31 (clamped where out of range), %0d digits",
			values_sent, digits_checked);
		$display("checked; zero and full-width values included, input back-pressure up to %0d cycles.",
			longest_backpressure);
		if (mismatches == 0) begin
			$display("PASS radix_digit_emitter_unit");
		end else begin
			$display("FAIL radix_digit_emitter_unit");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL radix_digit_emitter_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/rde_front.sv
hdl/rde_queue.sv
hdl/rde_back.sv
hdl/radix_digit_emitter_unit.sv
tb/tb_radix_digit_emitter_unit.sv
